// File: sv/sat_pkg.sv
// sat_pkg: shared widths, codes and defaults for the sorted array table
`timescale 1ns / 1ps

package sat_pkg;

    // field widths
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam int DEPTH_DEF = 16;

    // register reset values
    localparam logic [CNT_W-1:0] CAPACITY_RST = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b1;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INDEX = 2'd2;

endpackage

// File: sv/sorted_array_table.sv
// sorted_array_table: sorted key table with insert, lookup and remove
`timescale 1ns / 1ps
//
// Keeps up to DEPTH unsigned 32-bit keys in ascending or descending order.
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser (tuser = operation),
// results leave on m_tvalid/m_tready/m_tdata/m_tuser (tuser = status), one
// result per item. Registers capacity and descending are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// All keys live in a single-port-write, single-port-read memory with a
// registered read, walked by a small sequencer; each stepped element takes a
// read, then a compare or a write. Sequencer work from acceptance to result:
//   insert at the end: scan every key, then write; into an empty table: write
//   insert elsewhere: scan to the slot, shift the tail, write
//   lookup: one read; remove: move each entry above the index down one place
//   remove of the last entry, refused items and the unused code: none
// s_tready is high only while the sequencer is idle, one item at a time; the
// next item can be taken in the cycle after a result is loaded.
// A finished result sits in the output register; the next item is taken while
// it waits, but its own result is held until m_tready frees the register.
// Reset (aresetn low, synchronous) empties the table, sets capacity to 16 and
// ascending order; memory contents are not cleared, entries above the count
// are never read.

module sorted_array_table
    import sat_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // key[31:0], index[35:32], zero pad
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // value[31:0], count[36:32], zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status[1:0]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // count never exceeds 31, so at most 32 entries are ever addressed
    localparam int MEM_D = (DEPTH < 32) ? DEPTH : 32;
    localparam int MAW   = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam logic [CNT_W:0] DEPTH_CAP = (DEPTH > 32) ? 6'd32 : 6'(DEPTH);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SCAN_RD  = 11'b00000000010,
        S_SCAN_CMP = 11'b00000000100,
        S_SHIFT_RD = 11'b00000001000,
        S_SHIFT_WR = 11'b00000010000,
        S_PUT      = 11'b00000100000,
        S_LOOK_RD  = 11'b00001000000,
        S_LOOK_DAT = 11'b00010000000,
        S_REM_RD   = 11'b00100000000,
        S_REM_WR   = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    capacity_reg;
    logic                descending_reg;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [KEY_W-1:0]    value_reg, value_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [STAT_W-1:0]   m_user_reg;

    logic [KEY_W-1:0]    mem_reg [MEM_D];
    logic [KEY_W-1:0]    rdata_reg;
    logic [CNT_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    wr_addr;
    logic [KEY_W-1:0]    wr_data;
    logic                wr_en;

    logic                s_accept;
    logic [CNT_W:0]      limit;
    logic [CNT_W-1:0]    in_idx;
    logic                key_ahead;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign in_idx = {1'b0, s_tdata[KEY_W +: IDX_W]};

    // capacity saturates at the table depth
    assign limit = ({1'b0, capacity_reg} > DEPTH_CAP) ? DEPTH_CAP : {1'b0, capacity_reg};

    // stored key comes strictly before the new key in the current order
    assign key_ahead = descending_reg ? (rdata_reg > key_reg) : (rdata_reg < key_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= CAPACITY_RST;
            descending_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CAPACITY:   capacity_reg   <= cfg_data;
                REG_DESCENDING: descending_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // memory read address
    always_comb begin
        case (state_reg)
            S_SCAN_RD:  rd_addr = pos_reg;
            S_SHIFT_RD: rd_addr = i_reg - 5'd1;
            S_REM_RD:   rd_addr = i_reg + 5'd1;
            default:    rd_addr = i_reg;
        endcase
    end

    // memory write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_reg;
        wr_data = rdata_reg;
        case (state_reg)
            S_SHIFT_WR: wr_en = 1'b1;
            S_REM_WR:   wr_en = 1'b1;
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = key_reg;
            end
            default: ;
        endcase
    end

    // key storage, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr[MAW-1:0]] <= wr_data;
        end
        rdata_reg <= mem_reg[rd_addr[MAW-1:0]];
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        i_next      = i_reg;
        value_next  = value_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    key_next    = s_tdata[KEY_W-1:0];
                    value_next  = '0;
                    status_next = ST_DONE;
                    pos_next    = '0;
                    i_next      = in_idx;
                    state_next  = S_DONE;
                    case (s_tuser)
                        FUNC_INSERT: begin
                            if ({1'b0, count_reg} >= limit) begin
                                status_next = ST_FULL;
                            end else if (count_reg == '0) begin
                                state_next = S_PUT;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        FUNC_LOOKUP: begin
                            if (in_idx >= count_reg) begin
                                status_next = ST_INDEX;
                            end else begin
                                state_next = S_LOOK_RD;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (in_idx >= count_reg) begin
                                status_next = ST_INDEX;
                            end else if (in_idx + 5'd1 == count_reg) begin
                                count_next = count_reg - 5'd1;
                            end else begin
                                state_next = S_REM_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                i_next = count_reg;
                if (key_ahead) begin
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg + 5'd1 == count_reg) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end else begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                i_next = i_reg - 5'd1;
                if (i_reg - 5'd1 == pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_PUT: begin
                count_next = count_reg + 5'd1;
                state_next = S_DONE;
            end
            S_LOOK_RD: begin
                state_next = S_LOOK_DAT;
            end
            S_LOOK_DAT: begin
                value_next = rdata_reg;
                state_next = S_DONE;
            end
            S_REM_RD: begin
                state_next = S_REM_WR;
            end
            S_REM_WR: begin
                i_next = i_reg + 5'd1;
                if (i_reg + 5'd2 == count_reg) begin
                    count_next = count_reg - 5'd1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_REM_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        i_reg      <= i_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {3'b000, count_reg, value_reg};
            m_user_reg <= status_reg;
        end
    end

    // an accepted item always starts the sequencer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again right after an accepted item");

    // writes stay inside the table depth
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ({1'b0, wr_addr} < DEPTH_CAP))
        else $error("memory write beyond table depth");

    // the shift never passes the insert slot
    a_shift_above_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_RD) |-> (i_reg > pos_reg))
        else $error("shift index at or below insert position");

endmodule
